// ===== rtl/btp_pkg.sv =====
// ----------------------------------------------------------------------------
// btp_pkg: shared types and constants of the background test pattern unit
// Field widths, register codes, ramp coefficients and checker colors.
// ----------------------------------------------------------------------------
package btp_pkg;

  localparam int COORD_W = 12;  // pixel_x / pixel_y
  localparam int DIM_W   = 13;  // frame_width / frame_height
  localparam int CFG_W   = 13;  // widest register
  localparam int COLOR_W = 32;
  localparam int CHAN_W  = 8;
  localparam int N_CHAN  = 3;   // r, g, b

  // divider: dividend is coord * k with k < 2**QUO_W, quotient < k
  localparam int QUO_W = 7;
  localparam int KMUL_W = 7;
  localparam int DVD_W = 20;

  // tile of 20: (v >> 2) / 5 as multiply by reciprocal, exact below 2730
  localparam int TILE_IN_W  = 11;
  localparam int TILE_RECIP = 1639;
  localparam int TILE_SHIFT = 13;
  localparam int TILE_PRD_W = 22;

  typedef enum logic [1:0] {
    REG_PATTERN_MODE = 2'd0,
    REG_FRAME_WIDTH  = 2'd1,
    REG_FRAME_HEIGHT = 2'd2,
    REG_FLIP_ROWS    = 2'd3
  } cfg_reg_e;

  localparam logic [COLOR_W-1:0] ALPHA_OPAQUE = 32'hFF00_0000;
  localparam logic [COLOR_W-1:0] TOP_DARK     = 32'hFF20_4020;
  localparam logic [COLOR_W-1:0] TOP_LIGHT    = 32'hFF80_A080;
  localparam logic [COLOR_W-1:0] BOTTOM_DARK  = 32'hFF40_2020;
  localparam logic [COLOR_W-1:0] BOTTOM_LIGHT = 32'hFFA0_8080;

  localparam logic [CHAN_W-1:0] RAMP_BASE [N_CHAN] = '{8'd24, 8'd40, 8'd32};
  localparam logic [KMUL_W-1:0] RAMP_KX   [N_CHAN] = '{7'd83, 7'd37, 7'd19};
  localparam logic [KMUL_W-1:0] RAMP_KY   [N_CHAN] = '{7'd29, 7'd71, 7'd47};

  // per-word sideband that rides along the divider stages
  typedef struct packed {
    logic err;
    logic parity;
    logic top;
  } side_t;

endpackage

// ===== rtl/btp_if.sv =====
// ----------------------------------------------------------------------------
// btp_if: valid/ready channels of the background test pattern unit
// Pixel request, pixel result and register write channels.
// ----------------------------------------------------------------------------
interface btp_px_in_if;
  logic                        valid;
  logic                        ready;
  logic [btp_pkg::COORD_W-1:0] pixel_x;
  logic [btp_pkg::COORD_W-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface btp_px_out_if;
  logic                        valid;
  logic                        ready;
  logic [btp_pkg::COLOR_W-1:0] pixel_color;
  logic                        coord_error;

  modport source (output valid, output pixel_color, output coord_error, input ready);
  modport sink   (input valid, input pixel_color, input coord_error, output ready);
endinterface

interface btp_cfg_if;
  logic                      valid;
  logic                      ready;
  btp_pkg::cfg_reg_e         index;
  logic [btp_pkg::CFG_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/btp_ramp_div.sv =====
// ----------------------------------------------------------------------------
// btp_ramp_div: pipelined restoring divider for one gradient term
// One quotient bit per stage, MSB first; each stage has its own enable.
// ----------------------------------------------------------------------------
module btp_ramp_div (
  input  logic                        clk_i,
  input  logic [btp_pkg::QUO_W-1:0]   en_i,
  input  logic [btp_pkg::DVD_W-1:0]   dividend_i,
  input  logic [btp_pkg::DIM_W-1:0]   divisor_i,
  output logic [btp_pkg::QUO_W-1:0]   quotient_o
);

  localparam int QW = btp_pkg::QUO_W;
  localparam int DW = btp_pkg::DVD_W;

  logic [DW-1:0] rem_q [QW-1];
  logic [QW-1:0] quo_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    localparam int SH = QW - 1 - k;
    logic [DW-1:0] rem_in;
    logic [QW-1:0] quo_in;
    logic [DW-1:0] dsr;
    logic          take;
    logic [QW-1:0] quo_d;

    if (k == 0) begin : g_first
      assign rem_in = dividend_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign dsr   = DW'(divisor_i) << SH;
    assign take  = (rem_in >= dsr);
    assign quo_d = quo_in | (take ? (QW'(1) << SH) : '0);

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        quo_q[k] <= quo_d;
      end
    end

    // last step needs no remainder
    if (k < QW - 1) begin : g_rem
      logic [DW-1:0] rem_d;
      assign rem_d = take ? (rem_in - dsr) : rem_in;
      always_ff @(posedge clk_i) begin
        if (en_i[k]) begin
          rem_q[k] <= rem_d;
        end
      end
    end
  end

  assign quotient_o = quo_q[QW-1];

endmodule

// ===== rtl/background_test_pattern_pixel_unit.sv =====
// ----------------------------------------------------------------------------
// background_test_pattern_pixel_unit: checker / gradient test pattern pixel
// Throughput: one word per cycle while the output is not stalled; the seven divider stages set the depth.
// Each stage holds its word under stall, bubbles are squeezed out.
// Reset clears all stage valid bits and loads the default registers
// (checker mode, 640 x 480, no flip).
// ----------------------------------------------------------------------------
module background_test_pattern_pixel_unit #(
  parameter int MAX_DIM = 4096
) (
  input  logic clk_i,
  input  logic rst_ni,
  btp_px_in_if.sink    pix_i,
  btp_px_out_if.source pix_o,
  btp_cfg_if.sink      cfg_i
);

  localparam int CW = btp_pkg::COORD_W;
  localparam int DW = btp_pkg::DIM_W;
  localparam int VW = btp_pkg::DVD_W;
  localparam int QW = btp_pkg::QUO_W;
  localparam int NC = btp_pkg::N_CHAN;
  // input reg, row stage, product stage, divider steps, output reg
  localparam int DIV0 = 3;
  localparam int NSTG = DIV0 + QW + 1;
  localparam int LAST = NSTG - 1;

  // -------------------------------------------------------------- registers
  logic          pattern_mode_q;
  logic [DW-1:0] frame_width_q;
  logic [DW-1:0] frame_height_q;
  logic          flip_rows_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_mode_q <= 1'b0;
      frame_width_q  <= DW'(640);
      frame_height_q <= DW'(480);
      flip_rows_q    <= 1'b0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        btp_pkg::REG_PATTERN_MODE: pattern_mode_q <= cfg_i.data[0];
        btp_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_i.data[DW-1:0];
        btp_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_i.data[DW-1:0];
        btp_pkg::REG_FLIP_ROWS:    flip_rows_q    <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  logic [DW-1:0] w, h;
  assign w = (32'(frame_width_q)  > MAX_DIM) ? DW'(MAX_DIM) : frame_width_q;
  assign h = (32'(frame_height_q) > MAX_DIM) ? DW'(MAX_DIM) : frame_height_q;

  // ------------------------------------------------------- stage enables
  logic [NSTG-1:0] v_q;
  logic [NSTG-1:0] en;

  always_comb begin
    en[LAST] = ~v_q[LAST] | pix_o.ready;
    for (int i = LAST - 1; i >= 0; i--) begin
      en[i] = ~v_q[i] | en[i+1];
    end
  end

  assign pix_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= pix_i.valid;
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) v_q[i] <= v_q[i-1];
      end
    end
  end

  // ------------------------------------------------- stage 0: input word
  logic [CW-1:0] x0_q, y0_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      x0_q <= pix_i.pixel_x;
      y0_q <= pix_i.pixel_y;
    end
  end

  // --------------------------------------- stage 1: range check, source row
  logic [CW-1:0] x1_q;
  logic [DW-1:0] row1_q, row1_d;
  logic          err1_q, err1_d;

  assign err1_d = (DW'(x0_q) >= w) || (DW'(y0_q) >= h);
  // out-of-frame words may wrap here, the output mux blacks them out
  assign row1_d = flip_rows_q ? (h - DW'(1) - DW'(y0_q)) : DW'(y0_q);

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      x1_q   <= x0_q;
      row1_q <= row1_d;
      err1_q <= err1_d;
    end
  end

  // ------------------------------ stage 2: ramp products, tile parity, half
  logic [VW-1:0] dvd_x_q [NC];
  logic [VW-1:0] dvd_y_q [NC];
  btp_pkg::side_t side_q [DIV0+QW-1:2];
  btp_pkg::side_t side2_d;

  logic [btp_pkg::TILE_PRD_W-1:0] tile_x, tile_y;

  // tile of 20 pixels: drop two bits, then divide by five
  assign tile_x = btp_pkg::TILE_PRD_W'(btp_pkg::TILE_IN_W'(x1_q >> 2))
                * btp_pkg::TILE_PRD_W'(btp_pkg::TILE_RECIP);
  assign tile_y = btp_pkg::TILE_PRD_W'(btp_pkg::TILE_IN_W'(row1_q >> 2))
                * btp_pkg::TILE_PRD_W'(btp_pkg::TILE_RECIP);

  assign side2_d.err    = err1_q;
  assign side2_d.parity = tile_x[btp_pkg::TILE_SHIFT] ^ tile_y[btp_pkg::TILE_SHIFT];
  assign side2_d.top    = (row1_q < (h >> 1));

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      for (int c = 0; c < NC; c++) begin
        dvd_x_q[c] <= VW'(x1_q)   * VW'(btp_pkg::RAMP_KX[c]);
        dvd_y_q[c] <= VW'(row1_q) * VW'(btp_pkg::RAMP_KY[c]);
      end
    end
  end

  // ------------------------------------------------ stages 3..9: dividers
  logic [QW-1:0] quo_x [NC];
  logic [QW-1:0] quo_y [NC];

  for (genvar c = 0; c < NC; c++) begin : g_chan
    btp_ramp_div u_div_x (
      .clk_i      (clk_i),
      .en_i       (en[DIV0+QW-1:DIV0]),
      .dividend_i (dvd_x_q[c]),
      .divisor_i  (w),
      .quotient_o (quo_x[c])
    );
    btp_ramp_div u_div_y (
      .clk_i      (clk_i),
      .en_i       (en[DIV0+QW-1:DIV0]),
      .dividend_i (dvd_y_q[c]),
      .divisor_i  (h),
      .quotient_o (quo_y[c])
    );
  end

  // sideband rides from the product stage through the divider stages
  always_ff @(posedge clk_i) begin
    if (en[2]) side_q[2] <= side2_d;
    for (int i = DIV0; i < DIV0 + QW; i++) begin
      if (en[i]) side_q[i] <= side_q[i-1];
    end
  end

  // ---------------------------------------------- stage 10: color assembly
  btp_pkg::side_t side_l;
  logic [btp_pkg::CHAN_W-1:0] chan [NC];
  logic [btp_pkg::COLOR_W-1:0] color_d, color_q;
  logic err_q;

  assign side_l = side_q[DIV0+QW-1];

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      chan[c] = btp_pkg::RAMP_BASE[c] + btp_pkg::CHAN_W'(quo_x[c])
              + btp_pkg::CHAN_W'(quo_y[c]);
    end
    if (side_l.err) begin
      color_d = '0;
    end else if (pattern_mode_q) begin
      color_d = btp_pkg::ALPHA_OPAQUE | {8'h00, chan[2], chan[1], chan[0]};
    end else if (side_l.top) begin
      color_d = side_l.parity ? btp_pkg::TOP_LIGHT : btp_pkg::TOP_DARK;
    end else begin
      color_d = side_l.parity ? btp_pkg::BOTTOM_LIGHT : btp_pkg::BOTTOM_DARK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[LAST]) begin
      color_q <= color_d;
      err_q   <= side_l.err;
    end
  end

  assign pix_o.valid       = v_q[LAST];
  assign pix_o.pixel_color = color_q;
  assign pix_o.coord_error = err_q;

  // ------------------------------------------------------------ assertions
  a_err_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_o.valid && pix_o.coord_error |-> pix_o.pixel_color == '0)
    else $error("out-of-frame word carries a nonzero pixel");

  a_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_o.valid && !pix_o.coord_error |-> pix_o.pixel_color[31:24] == 8'hFF)
    else $error("in-frame pixel is not opaque");

  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pix_i.ready |-> (v_q == {NSTG{1'b1}}) && !pix_o.ready)
    else $error("input stalled while pipeline has a bubble");

  a_red_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_o.valid && !pix_o.coord_error && pattern_mode_q
      |-> pix_o.pixel_color[7:0] >= 8'd24)
    else $error("gradient red channel below its base");

endmodule
